[src/bbu_pkg.sv]
// ----------------------------------------------------------------------------
// bbu_pkg
// Shared sizes and arithmetic constants of the bilinear block upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bbu_pkg;

  localparam int SRC_WIDTH  = 32;
  localparam int SRC_HEIGHT = 24;
  localparam int STEPS      = 8;

  localparam int PIX_W   = 16;
  localparam int COORD_W = 8;
  localparam int COL_W   = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
  localparam int ROW_W   = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int WGT_W   = $clog2(STEPS + 1);
  localparam int TERM_W  = PIX_W + 1;
  localparam int PROD_W  = PIX_W + WGT_W + 1;

  // truncating divide by STEPS as a multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = PROD_W + $clog2(STEPS);
  localparam int RECIP_W     = RECIP_SHIFT;
  localparam longint RECIP_L = ((longint'(1) << RECIP_SHIFT) + longint'(STEPS) - 1)
                               / longint'(STEPS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  typedef logic signed [PIX_W-1:0]  pix_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic [WGT_W-1:0]         wgt_t;

endpackage

`default_nettype wire

[src/bilinear_block_upscaler.sv]
// ----------------------------------------------------------------------------
// bilinear_block_upscaler
// Upscales a raster stream of signed pixels by STEPS in both directions.
// ----------------------------------------------------------------------------
// Each input word at source row and column both at least one completes a cell
// of four neighbours and yields a block of STEPS x STEPS output words in
// row-major order, the final one flagged by last_of_block_o. The block takes
// one input word at a time: a word in column zero is taken without a stall,
// any other word passes through the line store states, and a word that yields
// a block also passes through the block computation, which the output stall
// can hold. All arithmetic goes through the single multiply-divide unit, six
// terms per output pixel, one after another. The previous source row sits in a
// line store with one read and one write port, accessed in the states S_RD0,
// S_RD1 and S_RD2 after the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_block_upscaler
  import bbu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pix_t               pixel_value_i,
  input  wire logic               frame_start_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [COORD_W-1:0]      out_x_o,
  output logic [COORD_W-1:0]      out_y_o,
  output pix_t                    out_value_o,
  output logic                    last_of_block_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_RD1  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;

  localparam logic [2:0] OP_TL  = 3'd0;
  localparam logic [2:0] OP_TR  = 3'd1;
  localparam logic [2:0] OP_BL  = 3'd2;
  localparam logic [2:0] OP_BR  = 3'd3;
  localparam logic [2:0] OP_TOP = 3'd4;
  localparam logic [2:0] OP_BOT = 3'd5;

  localparam logic [3:0] ST_LAST = 4'd11;
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(STEPS - 1);

  logic [2:0]        state_q, state_d;
  logic [COL_W-1:0]  col_cnt_q, col_cnt_d;
  logic [ROW_W-1:0]  row_cnt_q, row_cnt_d;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [COL_W-1:0]  c_sel;
  logic [ROW_W-1:0]  r_sel;
  logic [3:0]        st_q, st_d;
  logic [STEP_W-1:0] sx_q, sx_d, sy_q, sy_d;
  logic              accept;
  logic              emit;
  logic              last_step;

  pix_t  left_q, bl_q, br_q, tl_q, tr_q, top_q, bot_q;
  term_t acc_q;
  term_t term;
  pix_t  op_value;
  wgt_t  op_weight;
  logic [2:0] op_sel;

  logic [PIX_W-1:0]  line_mem [SRC_WIDTH];
  logic [PIX_W-1:0]  mem_rdata_q;
  logic [COL_W-1:0]  mem_raddr;
  logic [COL_W-1:0]  mem_waddr;
  logic [PIX_W-1:0]  mem_wdata;
  logic              mem_we;

  logic              out_valid_q;
  logic [COORD_W-1:0] out_x_q, out_y_q;
  pix_t              out_value_q;
  logic              out_last_q;
  logic [15:0]       x_full, y_full;
  pix_t              value_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign c_sel      = frame_start_i ? '0 : col_cnt_q;
  assign r_sel      = frame_start_i ? '0 : row_cnt_q;

  // position counters
  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (accept) begin
      if (c_sel == COL_W'(SRC_WIDTH - 1)) begin
        col_cnt_d = '0;
        row_cnt_d = (r_sel == ROW_W'(SRC_HEIGHT - 1)) ? '0 : ROW_W'(r_sel + 1'b1);
      end else begin
        col_cnt_d = COL_W'(c_sel + 1'b1);
        row_cnt_d = r_sel;
      end
    end
  end

  // line store
  always_comb begin
    mem_raddr = (state_q == S_RD0) ? COL_W'(col_q - 1'b1) : col_q;
    mem_we    = 1'b0;
    mem_waddr = col_q;
    mem_wdata = br_q;
    if (state_q == S_RD1) begin
      mem_we    = 1'b1;
      mem_waddr = COL_W'(col_q - 1'b1);
      mem_wdata = bl_q;
    end else if (state_q == S_RD2 && col_q == COL_W'(SRC_WIDTH - 1)) begin
      mem_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= line_mem[mem_raddr];
  end

  // operand select for the shared unit
  assign op_sel = st_q[3:1];

  always_comb begin
    unique case (op_sel)
      OP_TL: begin
        op_value  = tl_q;
        op_weight = wgt_t'(STEPS) - wgt_t'(sx_q);
      end
      OP_TR: begin
        op_value  = tr_q;
        op_weight = wgt_t'(sx_q);
      end
      OP_BL: begin
        op_value  = bl_q;
        op_weight = wgt_t'(STEPS) - wgt_t'(sx_q);
      end
      OP_BR: begin
        op_value  = br_q;
        op_weight = wgt_t'(sx_q);
      end
      OP_TOP: begin
        op_value  = top_q;
        op_weight = wgt_t'(STEPS) - wgt_t'(sy_q);
      end
      OP_BOT: begin
        op_value  = bot_q;
        op_weight = wgt_t'(sy_q);
      end
      default: begin
        op_value  = bot_q;
        op_weight = wgt_t'(sy_q);
      end
    endcase
  end

  bbu_term_unit u_term (
    .clk_i       (clk_i),
    .op_value_i  (op_value),
    .op_weight_i (op_weight),
    .term_o      (term)
  );

  assign emit      = (state_q == S_CALC) && (st_q == ST_LAST)
                     && (!out_valid_q || !out_stall_i);
  assign last_step = (sx_q == STEP_MAX) && (sy_q == STEP_MAX);
  assign value_d   = pix_t'(acc_q + term);

  // sequencer
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && c_sel != '0) begin
          state_d = S_RD0;
        end
      end
      S_RD0: begin
        state_d = S_RD1;
      end
      S_RD1: begin
        state_d = S_RD2;
      end
      S_RD2: begin
        st_d = '0;
        sx_d = '0;
        sy_d = '0;
        state_d = (row_q != '0) ? S_CALC : S_IDLE;
      end
      S_CALC: begin
        if (st_q != ST_LAST) begin
          st_d = st_q + 4'd1;
        end else if (emit) begin
          st_d = '0;
          if (last_step) begin
            state_d = S_IDLE;
          end else if (sx_q == STEP_MAX) begin
            sx_d = '0;
            sy_d = sy_q + 1'b1;
          end else begin
            sx_d = sx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      st_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      st_q      <= st_d;
      sx_q      <= sx_d;
      sy_q      <= sy_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q  <= c_sel;
      row_q  <= r_sel;
      bl_q   <= left_q;
      br_q   <= pixel_value_i;
      left_q <= pixel_value_i;
    end
    if (state_q == S_RD1) begin
      tl_q <= mem_rdata_q;
    end
    if (state_q == S_RD2) begin
      tr_q <= mem_rdata_q;
    end
    if (state_q == S_CALC && st_q[0]) begin
      unique case (op_sel)
        OP_TR:   top_q <= pix_t'(acc_q + term);
        OP_BR:   bot_q <= pix_t'(acc_q + term);
        OP_BOT:  acc_q <= acc_q;
        default: acc_q <= term;
      endcase
    end
    if (emit) begin
      out_x_q     <= x_full[COORD_W-1:0];
      out_y_q     <= y_full[COORD_W-1:0];
      out_value_q <= value_d;
      out_last_q  <= last_step;
    end
  end

  assign x_full = 16'(COL_W'(col_q - 1'b1)) * 16'(STEPS) + 16'(sx_q);
  assign y_full = 16'(ROW_W'(row_q - 1'b1)) * 16'(STEPS) + 16'(sy_q);

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_value_o     = out_value_q;
  assign last_of_block_o = out_last_q;

  // checks
  a_calc_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC |-> (col_q != '0) && (row_q != '0))
    else $error("block computed outside interior");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC |-> st_q <= ST_LAST)
    else $error("step counter out of range");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_step) |=> (state_q == S_IDLE) && out_valid_q && out_last_q)
    else $error("block end not followed by idle");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_IDLE) || (state_q == S_RD0))
    else $error("unexpected state after accept");

endmodule

`default_nettype wire

[src/bbu_term_unit.sv]
// ----------------------------------------------------------------------------
// bbu_term_unit
// Shared multiply-divide unit: term = trunc(value * weight / STEPS).
// The product is registered, the scaled quotient is formed combinationally from it.
// ----------------------------------------------------------------------------
`default_nettype none

module bbu_term_unit
  import bbu_pkg::*;
(
  input  wire logic  clk_i,
  input  wire pix_t  op_value_i,
  input  wire wgt_t  op_weight_i,
  output term_t      term_o
);

  logic signed [PROD_W-1:0]         prod_d;
  logic signed [PROD_W-1:0]         prod_q;
  logic [PROD_W-1:0]                mag;
  logic [PROD_W+RECIP_W-1:0]        scaled;
  logic [TERM_W-1:0]                quo_mag;

  assign prod_d = PROD_W'(op_value_i) * PROD_W'($signed({1'b0, op_weight_i}));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_comb begin
    mag     = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    scaled  = (PROD_W + RECIP_W)'(mag) * (PROD_W + RECIP_W)'(RECIP);
    quo_mag = scaled[RECIP_SHIFT +: TERM_W];
    term_o  = prod_q[PROD_W-1] ? term_t'(-quo_mag) : term_t'(quo_mag);
  end

endmodule

`default_nettype wire

[verif/bilinear_block_upscaler_tb.sv]
// ----------------------------------------------------------------------------
// bilinear_block_upscaler_tb
// Self-checking testbench for the bilinear block upscaler.
// ----------------------------------------------------------------------------
// Source words are queued up front and sent by a clocked driver with random
// gaps. A scoreboard keeps its own copy of the line store, the left pixel and
// the row and column position, predicts every output block for each accepted
// word and compares each output word with the oldest prediction. The run covers
// extreme pixel values, frames cut short by frame_start and rows with the last
// column.
// ----------------------------------------------------------------------------

module bilinear_block_upscaler_tb;
  import bbu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BLOCK_CYCLES = 4 + 12 * STEPS * STEPS;
  localparam int STUCK_LIMIT  = 8 * BLOCK_CYCLES;
  localparam int DRAIN_CYCLES = 2 * BLOCK_CYCLES;
  localparam pix_t PIX_MAX    = 16'sh7fff;
  localparam pix_t PIX_MIN    = -16'sh8000;

  typedef struct {
    pix_t value;
    logic frame_start;
  } src_word_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    pix_t               value;
    logic               last;
  } up_pixel_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  pix_t               pixel_value_i = '0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [COORD_W-1:0] out_x_o;
  logic [COORD_W-1:0] out_y_o;
  pix_t               out_value_o;
  logic               last_of_block_o;

  src_word_t word_q[$];
  up_pixel_t expected_q[$];

  int words_accepted = 0;
  int phase_a_words  = 0;
  int phase_b_words  = 0;
  int mismatch_count = 0;
  int stuck_cycles   = 0;

  // scoreboard copy of the block state
  int line_mem[SRC_WIDTH];
  int left_pix = 0;
  int col_pos  = 0;
  int row_pos  = 0;

  bilinear_block_upscaler DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_value_i  (pixel_value_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_x_o        (out_x_o),
    .out_y_o        (out_y_o),
    .out_value_o    (out_value_o),
    .last_of_block_o(last_of_block_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int blend(int a, int b, int s);
    return a * (STEPS - s) / STEPS + b * s / STEPS;
  endfunction

  task automatic upscale_word(input pix_t pix, input logic fs);
    int col;
    int row;
    int tl;
    int tr;
    int bl;
    int br;
    int top;
    int bot;
    up_pixel_t px;
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    if (col >= 1) begin
      tl = line_mem[col-1];
      tr = line_mem[col];
      bl = left_pix;
      br = pix;
      if (row >= 1) begin
        for (int sy = 0; sy < STEPS; sy++) begin
          for (int sx = 0; sx < STEPS; sx++) begin
            top = blend(tl, tr, sx);
            bot = blend(bl, br, sx);
            px.x     = COORD_W'((col - 1) * STEPS + sx);
            px.y     = COORD_W'((row - 1) * STEPS + sy);
            px.value = pix_t'(blend(top, bot, sy));
            px.last  = (sy == STEPS - 1) && (sx == STEPS - 1);
            expected_q.push_back(px);
          end
        end
      end
      line_mem[col-1] = left_pix;
      if (col == SRC_WIDTH - 1) line_mem[col] = pix;
    end
    left_pix = pix;
    col++;
    if (col >= SRC_WIDTH) begin
      col = 0;
      row++;
      if (row >= SRC_HEIGHT) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endtask

  function automatic int send_gap_pct();
    if (words_accepted < phase_a_words) return 36;
    if (words_accepted < phase_b_words) return 63;
    return 0;
  endfunction

  function automatic int recv_stall_pct();
    if (words_accepted < phase_a_words) return 63;
    if (words_accepted < phase_b_words) return 36;
    return 0;
  endfunction

  function automatic pix_t rand_pixel();
    case ($urandom_range(9))
      0: return PIX_MAX;
      1: return PIX_MIN;
      2: return pix_t'(int'($urandom_range(200)) - 100);
      default: return pix_t'($urandom_range(16'hffff));
    endcase
  endfunction

  task automatic add_word(input pix_t v, input logic fs);
    src_word_t w;
    w.value       = v;
    w.frame_start = fs;
    word_q.push_back(w);
  endtask

  task automatic add_frame_run(input int n);
    add_word(rand_pixel(), 1'b1);
    repeat (n - 1) add_word(rand_pixel(), 1'b0);
  endtask

  // mostly frame runs of one to three rows plus part of a row, some cut-short frames and loose words
  task automatic add_random_words(input int target);
    int kind;
    int len;
    while (word_q.size() < target) begin
      kind = int'($urandom_range(9));
      case (kind)
        0: len = int'($urandom_range(1, SRC_WIDTH - 1));
        1: len = int'($urandom_range(1, 40));
        default: len = SRC_WIDTH * int'($urandom_range(1, 3))
                       + int'($urandom_range(SRC_WIDTH - 1));
      endcase
      if (len > target - word_q.size()) len = target - word_q.size();
      if (kind == 1) repeat (len) add_word(rand_pixel(), 1'b0);
      else add_frame_run(len);
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      pixel_value_i <= '0;
      frame_start_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (word_q.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
        in_valid_i    <= 1'b1;
        pixel_value_i <= word_q[0].value;
        frame_start_i <= word_q[0].frame_start;
        void'(word_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_stall_pct();
    end
  end

  // scoreboard and watchdog
  always @(posedge clk_i) begin
    up_pixel_t want;
    logic in_fire;
    logic out_fire;
    if (rst_ni) begin
      in_fire  = in_valid_i && !in_stall_o;
      out_fire = out_valid_o && !out_stall_i;
      if (in_fire) begin
        upscale_word(pixel_value_i, frame_start_i);
        words_accepted <= words_accepted + 1;
      end
      if (out_fire) begin
        if (expected_q.size() == 0) begin
          $error("output word with nothing expected: x %0d y %0d value %0d",
                 out_x_o, out_y_o, out_value_o);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_x_o !== want.x) begin
            $error("out_x expected %0d actual %0d", want.x, out_x_o);
            mismatch_count++;
          end
          if (out_y_o !== want.y) begin
            $error("out_y expected %0d actual %0d", want.y, out_y_o);
            mismatch_count++;
          end
          if (out_value_o !== want.value) begin
            $error("out_value expected %0d actual %0d", want.value, out_value_o);
            mismatch_count++;
          end
          if (last_of_block_o !== want.last) begin
            $error("last_of_block expected %0d actual %0d", want.last, last_of_block_o);
            mismatch_count++;
          end
        end
      end
      if (in_fire || out_fire) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    pix_t row0_pat[4];
    pix_t row1_pat[8];
    int total_words;
    row0_pat = '{PIX_MAX, PIX_MIN, 16'sd0, -16'sd1};
    row1_pat = '{PIX_MIN, PIX_MAX, PIX_MIN, PIX_MAX, PIX_MAX, 16'sd0, -16'sd1, 16'sd1};

    // directed: extreme row followed by extreme cells, then a frame cut short
    add_word(PIX_MIN, 1'b1);
    for (int c = 1; c < SRC_WIDTH; c++) add_word(row0_pat[c % 4], 1'b0);
    foreach (row1_pat[i]) add_word(row1_pat[i], 1'b0);
    add_frame_run(3);
    add_random_words(135);
    phase_a_words = word_q.size();
    add_random_words(270);
    phase_b_words = word_q.size();
    add_random_words(400);
    total_words = word_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_accepted != total_words) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
